FILE: rtl/crt_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and state encodings of the camera-facing ribbon trail.
// Used by every module of the block but crt_ram; depends on nothing else.
package crt_pkg;

    localparam int unsigned WINDOW_LEN_DEF = 32;
    localparam int unsigned COORD_W        = 32;
    localparam int unsigned HW_W           = 31;
    localparam int unsigned U_W            = 16;
    localparam logic [HW_W-1:0] HW_RESET   = 31'd32768;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } point_t;

    // One segment of the walk, handed from the front to the back
    typedef struct packed {
        point_t         p0;
        point_t         p1;
        point_t         cam;
        logic [U_W-1:0] u;
        logic           last;
    } seg_job_t;

    // One strip vertex as it leaves the block
    typedef struct packed {
        coord_t         x;
        coord_t         y;
        coord_t         z;
        logic [U_W-1:0] u;
        logic           v;
        logic           last;
    } vertex_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_READ,
        F_PUSH
    } front_state_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_SCALE,
        B_MUL,
        B_MAG,
        B_NORM,
        B_SQ,
        B_SQRT,
        B_DIVMUL,
        B_DIVLD,
        B_DIVIT,
        B_OUT0,
        B_OUT1
    } back_state_t;

endpackage

FILE: rtl/crt_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module crt_ram #(
    parameter int unsigned WIDTH = 96,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port, holds its data while rd_en is low
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/crt_front.sv
`timescale 1ns / 1ps
// Front end: accepts points, keeps the history window in a RAM and walks it
// newest to oldest, pushing one segment job per pair. Depends on crt_pkg, crt_ram.
module crt_front #(
    parameter int unsigned WINDOW_LEN = crt_pkg::WINDOW_LEN_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  crt_pkg::point_t   s_point,
    input  crt_pkg::point_t   s_camera,
    output logic              push_valid,
    input  logic              push_ready,
    output crt_pkg::seg_job_t push_job
);
    import crt_pkg::*;

    localparam int unsigned IDX_W = $clog2(WINDOW_LEN);
    localparam int unsigned CNT_W = $clog2(WINDOW_LEN + 1);
    localparam int unsigned U_QUO = (1 << U_W) / WINDOW_LEN;
    localparam int unsigned U_REM = (1 << U_W) % WINDOW_LEN;
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(WINDOW_LEN - 1);
    localparam logic [CNT_W-1:0] FULL      = CNT_W'(WINDOW_LEN);

    front_state_t   state_reg, state_next;
    logic [IDX_W-1:0] newest_reg, newest_next;
    logic [CNT_W-1:0] held_reg, held_next;
    logic [CNT_W-1:0] segs_reg, segs_next;
    logic [CNT_W-1:0] seg_reg, seg_next;
    logic [IDX_W-1:0] addr_reg, addr_next;
    logic [U_W-1:0]   u_q_reg, u_q_next;
    logic [CNT_W-1:0] u_r_reg, u_r_next;
    point_t           cam_reg, cam_next;
    point_t           prev_reg, prev_next;

    logic             accept;
    logic [IDX_W-1:0] slot_inc;
    logic [CNT_W-1:0] held_inc;
    logic [IDX_W-1:0] addr_dec;
    logic             job_last;
    logic [CNT_W:0]   r_sum;
    logic             r_wrap;
    logic             ram_re;
    point_t           ram_rd;

    assign accept   = s_valid && s_ready;
    assign slot_inc = (newest_reg == LAST_SLOT) ? '0 : newest_reg + IDX_W'(1);
    assign held_inc = (held_reg == FULL) ? held_reg : held_reg + CNT_W'(1);
    assign addr_dec = (addr_reg == '0) ? LAST_SLOT : addr_reg - IDX_W'(1);
    assign job_last = ((seg_reg + CNT_W'(1)) == segs_reg);
    assign r_sum    = {1'b0, u_r_reg} + (CNT_W + 1)'(U_REM);
    assign r_wrap   = (r_sum >= (CNT_W + 1)'(WINDOW_LEN));

    // History window
    crt_ram #(
        .WIDTH ($bits(point_t)),
        .DEPTH (WINDOW_LEN)
    ) u_hist (
        .aclk    (aclk),
        .wr_en   (accept),
        .wr_addr (slot_inc),
        .wr_data (s_point),
        .rd_en   (ram_re),
        .rd_addr (addr_reg),
        .rd_data (ram_rd)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: begin
                if (accept && (held_reg != '0)) begin
                    state_next = F_READ;
                end
            end
            F_READ: begin
                state_next = F_PUSH;
            end
            F_PUSH: begin
                if (push_ready) begin
                    state_next = job_last ? F_IDLE : F_READ;
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb begin
        s_ready    = (state_reg == F_IDLE);
        ram_re     = (state_reg == F_READ);
        push_valid = (state_reg == F_PUSH);
    end

    // Build the job from the newer point and the freshly read older one
    always_comb begin
        push_job.p0   = prev_reg;
        push_job.p1   = ram_rd;
        push_job.cam  = cam_reg;
        push_job.u    = u_q_reg;
        push_job.last = job_last;
    end

    // Window bookkeeping and walk counters
    always_comb begin
        newest_next = newest_reg;
        held_next   = held_reg;
        segs_next   = segs_reg;
        seg_next    = seg_reg;
        addr_next   = addr_reg;
        u_q_next    = u_q_reg;
        u_r_next    = u_r_reg;
        cam_next    = cam_reg;
        prev_next   = prev_reg;
        if (accept) begin
            newest_next = slot_inc;
            held_next   = held_inc;
            segs_next   = held_inc - CNT_W'(1);
            seg_next    = '0;
            addr_next   = (slot_inc == '0) ? LAST_SLOT : slot_inc - IDX_W'(1);
            u_q_next    = '0;
            u_r_next    = '0;
            cam_next    = s_camera;
            prev_next   = s_point;
        end else if (push_valid && push_ready) begin
            // advance to the next older pair
            prev_next = ram_rd;
            seg_next  = seg_reg + CNT_W'(1);
            addr_next = addr_dec;
            if (r_wrap) begin
                u_r_next = CNT_W'(r_sum - (CNT_W + 1)'(WINDOW_LEN));
                u_q_next = u_q_reg + U_W'(U_QUO + 1);
            end else begin
                u_r_next = CNT_W'(r_sum);
                u_q_next = u_q_reg + U_W'(U_QUO);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= F_IDLE;
            newest_reg <= '0;
            held_reg   <= '0;
        end else begin
            state_reg  <= state_next;
            newest_reg <= newest_next;
            held_reg   <= held_next;
        end
    end

    always_ff @(posedge aclk) begin
        segs_reg <= segs_next;
        seg_reg  <= seg_next;
        addr_reg <= addr_next;
        u_q_reg  <= u_q_next;
        u_r_reg  <= u_r_next;
        cam_reg  <= cam_next;
        prev_reg <= prev_next;
    end

`ifndef SYNTHESIS
    a_held_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= FULL)
        else $error("point count beyond window length");

    a_last_ends_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_valid && push_ready && push_job.last) |=> (state_reg == F_IDLE))
        else $error("walk continued past the last segment");

    a_push_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_valid && !push_ready) |=> (push_valid && $stable(push_job)))
        else $error("segment job changed while waiting");
`endif

endmodule

FILE: rtl/crt_seg_queue.sv
`timescale 1ns / 1ps
// Short FIFO of segment jobs between the front and the back end.
// Depends on crt_pkg for the job type.
module crt_seg_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    output logic              push_ready,
    input  crt_pkg::seg_job_t push_job,
    output logic              pop_valid,
    input  logic              pop_ready,
    output crt_pkg::seg_job_t pop_job
);
    import crt_pkg::*;

    localparam int unsigned DEPTH = 2;
    localparam int unsigned PTR_W = $clog2(DEPTH);

    seg_job_t         mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != (PTR_W + 1)'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill count
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + (PTR_W + 1)'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - (PTR_W + 1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed beat
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

FILE: rtl/crt_back.sv
`timescale 1ns / 1ps
// Back end: turns a segment job into the arm vector (prescale, cross product; if it
// is nonzero, normalize, square root, three divisions), emits two vertices. Uses crt_pkg.
module crt_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       pop_valid,
    output logic                       pop_ready,
    input  crt_pkg::seg_job_t          pop_job,
    input  logic [crt_pkg::HW_W-1:0]   half_width,
    output logic                       m_valid,
    input  logic                       m_ready,
    output crt_pkg::vertex_t           m_vertex
);
    import crt_pkg::*;

    localparam logic [5:0] MUL_LAST = 6'd6;
    localparam logic [5:0] SQ_LAST  = 6'd3;
    localparam logic [5:0] DIV_LAST = 6'd32;

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        return v[32] ? 33'(-v) : 33'(v);
    endfunction

    function automatic logic [1:0] pre_shift(input logic [32:0] mor);
        logic [1:0] s;
        if (mor[32]) begin
            s = 2'd3;
        end else if (mor[31]) begin
            s = 2'd2;
        end else if (mor[30]) begin
            s = 2'd1;
        end else begin
            s = 2'd0;
        end
        return s;
    endfunction

    function automatic logic signed [30:0] pre_apply(input logic signed [32:0] v,
                                                     input logic [1:0] sh);
        logic [32:0] m;
        m = mag33(v) >> sh;
        return v[32] ? -31'(m) : 31'(m);
    endfunction

    function automatic coord_t sat_coord(input logic signed [33:0] v);
        coord_t r;
        if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
            r = v[31:0];
        end else if (v[33]) begin
            r = {1'b1, {(COORD_W - 1){1'b0}}};
        end else begin
            r = {1'b0, {(COORD_W - 1){1'b1}}};
        end
        return r;
    endfunction

    back_state_t state_reg, state_next;

    coord_t              p0_reg [3], p0_next [3];
    coord_t              cam_reg [3], cam_next [3];
    logic [U_W-1:0]      u_reg, u_next;
    logic                last_reg, last_next;
    logic signed [32:0]  line_reg [3], line_next [3];
    logic signed [30:0]  a_reg [3], a_next [3];
    logic signed [30:0]  b_reg [3], b_next [3];
    logic [5:0]          step_reg, step_next;
    logic signed [63:0]  prod_reg, prod_next;
    logic signed [61:0]  c_reg [3], c_next [3];
    logic                neg_reg [3], neg_next [3];
    logic [60:0]         m_reg [3], m_next [3];
    logic [61:0]         x_reg, x_next;
    logic [61:0]         r_reg, r_next;
    logic [60:0]         bit_reg, bit_next;
    logic [30:0]         len_reg, len_next;
    logic [1:0]          k_reg, k_next;
    logic [31:0]         rem_reg, rem_next;
    logic [32:0]         low_reg, low_next;
    logic [32:0]         quo_reg, quo_next;
    logic [31:0]         q_reg [3], q_next [3];
    logic                out_valid_reg, out_valid_next;
    vertex_t             out_reg, out_next;

    logic signed [31:0]  op_a;
    logic signed [31:0]  op_b;
    logic [32:0]         mor_line;
    logic [32:0]         mor_cam;
    logic [2:0]          mul_idx;
    logic [60:0]         m_or;
    logic                cross_zero;
    logic                norm_done;
    logic [62:0]         sq_t;
    logic                sq_ge;
    logic [61:0]         dividend;
    logic [31:0]         div_t;
    logic                div_ge;
    logic                out_load;
    logic signed [33:0]  arm [3];
    logic signed [33:0]  vsum [3];

    assign mor_line   = mag33(line_reg[0]) | mag33(line_reg[1]) | mag33(line_reg[2]);
    assign mor_cam    = mag33(33'(cam_reg[0])) | mag33(33'(cam_reg[1]))
                      | mag33(33'(cam_reg[2]));
    assign mul_idx    = step_reg[2:0] - 3'd1;
    assign m_or       = m_reg[0] | m_reg[1] | m_reg[2];
    assign cross_zero = (c_reg[0] == '0) && (c_reg[1] == '0) && (c_reg[2] == '0);
    assign norm_done  = m_or[29] && (m_or[60:30] == '0);
    assign sq_t       = {1'b0, r_reg} + {2'b00, bit_reg};
    assign sq_ge      = ({1'b0, x_reg} >= sq_t);
    assign dividend   = prod_reg[61:0] + 62'(len_reg >> 1);
    assign div_t      = {rem_reg[30:0], low_reg[32]};
    assign div_ge     = (div_t >= {1'b0, len_reg});

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:   if (pop_valid) state_next = B_SCALE;
            B_SCALE:  state_next = B_MUL;
            B_MUL:    if (step_reg == MUL_LAST) state_next = B_MAG;
            B_MAG:    state_next = cross_zero ? B_OUT0 : B_NORM;
            B_NORM:   if (norm_done) state_next = B_SQ;
            B_SQ:     if (step_reg == SQ_LAST) state_next = B_SQRT;
            B_SQRT:   if (bit_reg[0]) state_next = B_DIVMUL;
            B_DIVMUL: state_next = B_DIVLD;
            B_DIVLD:  state_next = B_DIVIT;
            B_DIVIT: begin
                if (step_reg == DIV_LAST) begin
                    state_next = (k_reg == 2'd2) ? B_OUT0 : B_DIVMUL;
                end
            end
            B_OUT0:   if (out_load) state_next = B_OUT1;
            B_OUT1:   if (out_load) state_next = B_IDLE;
            default:  state_next = B_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        pop_ready = (state_reg == B_IDLE);
        out_load  = ((state_reg == B_OUT0) || (state_reg == B_OUT1))
                 && (!out_valid_reg || m_ready);
    end

    // Vertex candidates: point plus arm on the first beat, minus on the second
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            arm[k]  = neg_reg[k] ? -34'({2'b00, q_reg[k]}) : 34'({2'b00, q_reg[k]});
            vsum[k] = 34'(p0_reg[k]) + ((state_reg == B_OUT1) ? -arm[k] : arm[k]);
        end
    end

    // Arm datapath
    always_comb begin
        p0_next   = p0_reg;
        cam_next  = cam_reg;
        u_next    = u_reg;
        last_next = last_reg;
        line_next = line_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        step_next = step_reg;
        c_next    = c_reg;
        neg_next  = neg_reg;
        m_next    = m_reg;
        x_next    = x_reg;
        r_next    = r_reg;
        bit_next  = bit_reg;
        len_next  = len_reg;
        k_next    = k_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        quo_next  = quo_reg;
        q_next    = q_reg;
        op_a      = '0;
        op_b      = '0;
        case (state_reg)
            B_IDLE: begin
                if (pop_valid) begin
                    p0_next[0]   = pop_job.p0.x;
                    p0_next[1]   = pop_job.p0.y;
                    p0_next[2]   = pop_job.p0.z;
                    cam_next[0]  = pop_job.cam.x;
                    cam_next[1]  = pop_job.cam.y;
                    cam_next[2]  = pop_job.cam.z;
                    u_next       = pop_job.u;
                    last_next    = pop_job.last;
                    line_next[0] = 33'(pop_job.p1.x) - 33'(pop_job.p0.x);
                    line_next[1] = 33'(pop_job.p1.y) - 33'(pop_job.p0.y);
                    line_next[2] = 33'(pop_job.p1.z) - 33'(pop_job.p0.z);
                    step_next    = '0;
                end
            end
            B_SCALE: begin
                // bring both vectors below 2^30 in every component
                for (int k = 0; k < 3; k++) begin
                    a_next[k] = pre_apply(line_reg[k], pre_shift(mor_line));
                    b_next[k] = pre_apply(33'(cam_reg[k]), pre_shift(mor_cam));
                end
                step_next = '0;
            end
            B_MUL: begin
                // one product per cycle, accumulate into the cross product
                case (step_reg[2:0])
                    3'd0: begin op_a = 32'(a_reg[1]); op_b = 32'(b_reg[2]); end
                    3'd1: begin op_a = 32'(a_reg[2]); op_b = 32'(b_reg[1]); end
                    3'd2: begin op_a = 32'(a_reg[2]); op_b = 32'(b_reg[0]); end
                    3'd3: begin op_a = 32'(a_reg[0]); op_b = 32'(b_reg[2]); end
                    3'd4: begin op_a = 32'(a_reg[0]); op_b = 32'(b_reg[1]); end
                    3'd5: begin op_a = 32'(a_reg[1]); op_b = 32'(b_reg[0]); end
                    default: begin op_a = '0; op_b = '0; end
                endcase
                if (step_reg != '0) begin
                    if (!mul_idx[0]) begin
                        c_next[mul_idx[2:1]] = prod_reg[61:0];
                    end else begin
                        c_next[mul_idx[2:1]] = c_reg[mul_idx[2:1]] - prod_reg[61:0];
                    end
                end
                step_next = (step_reg == MUL_LAST) ? '0 : step_reg + 6'd1;
            end
            B_MAG: begin
                for (int k = 0; k < 3; k++) begin
                    neg_next[k] = c_reg[k][61];
                    m_next[k]   = c_reg[k][61] ? 61'(-c_reg[k]) : 61'(c_reg[k]);
                    if (cross_zero) begin
                        q_next[k] = '0;
                    end
                end
            end
            B_NORM: begin
                // coarse then fine shifts until the largest lies in [2^29, 2^30)
                for (int k = 0; k < 3; k++) begin
                    if (m_or[60:38] != '0) begin
                        m_next[k] = m_reg[k] >> 8;
                    end else if (m_or[60:30] != '0) begin
                        m_next[k] = m_reg[k] >> 1;
                    end else if (m_or[29:21] == '0) begin
                        m_next[k] = m_reg[k] << 8;
                    end else if (!m_or[29]) begin
                        m_next[k] = m_reg[k] << 1;
                    end
                end
                step_next = '0;
            end
            B_SQ: begin
                if (step_reg != SQ_LAST) begin
                    op_a = {2'b00, m_reg[step_reg[1:0]][29:0]};
                    op_b = {2'b00, m_reg[step_reg[1:0]][29:0]};
                end
                if (step_reg == 6'd1) begin
                    x_next = prod_reg[61:0];
                end else if (step_reg != '0) begin
                    x_next = x_reg + prod_reg[61:0];
                end
                if (step_reg == SQ_LAST) begin
                    step_next = '0;
                    r_next    = '0;
                    bit_next  = 61'd1 << 60;
                end else begin
                    step_next = step_reg + 6'd1;
                end
            end
            B_SQRT: begin
                // one root digit per cycle
                if (sq_ge) begin
                    x_next = x_reg - 62'(sq_t);
                    r_next = (r_reg >> 1) + {1'b0, bit_reg};
                end else begin
                    r_next = r_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg[0]) begin
                    len_next = r_next[30:0];
                    k_next   = '0;
                end
            end
            B_DIVMUL: begin
                op_a = {2'b00, m_reg[k_reg][29:0]};
                op_b = {1'b0, half_width};
            end
            B_DIVLD: begin
                rem_next  = 32'(dividend[61:33]);
                low_next  = dividend[32:0];
                quo_next  = '0;
                step_next = '0;
            end
            B_DIVIT: begin
                // restoring division, one quotient bit per cycle
                rem_next  = div_ge ? div_t - {1'b0, len_reg} : div_t;
                low_next  = low_reg << 1;
                quo_next  = {quo_reg[31:0], div_ge};
                step_next = step_reg + 6'd1;
                if (step_reg == DIV_LAST) begin
                    q_next[k_reg] = quo_next[31:0];
                    k_next        = k_reg + 2'd1;
                end
            end
            default: begin
            end
        endcase
    end

    assign prod_next = 64'(op_a) * 64'(op_b);

    // Output register
    always_comb begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
            out_next.x     = sat_coord(vsum[0]);
            out_next.y     = sat_coord(vsum[1]);
            out_next.z     = sat_coord(vsum[2]);
            out_next.u     = u_reg;
            out_next.v     = (state_reg == B_OUT1);
            out_next.last  = (state_reg == B_OUT1) && last_reg;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_vertex = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        p0_reg   <= p0_next;
        cam_reg  <= cam_next;
        u_reg    <= u_next;
        last_reg <= last_next;
        line_reg <= line_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        step_reg <= step_next;
        prod_reg <= prod_next;
        c_reg    <= c_next;
        neg_reg  <= neg_next;
        m_reg    <= m_next;
        x_reg    <= x_next;
        r_reg    <= r_next;
        bit_reg  <= bit_next;
        len_reg  <= len_next;
        k_reg    <= k_next;
        rem_reg  <= rem_next;
        low_reg  <= low_next;
        quo_reg  <= quo_next;
        q_reg    <= q_next;
        out_reg  <= out_next;
    end

`ifndef SYNTHESIS
    a_norm_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_NORM && state_next == B_SQ) |-> (m_or[29] && m_or[60:30] == '0))
        else $error("normalization left the target range");

    a_root_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_SQRT && state_next == B_DIVMUL) |-> (len_next[30] || len_next[29]))
        else $error("arm length root below 2^29");

    a_rem_below: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_DIVIT) |-> (rem_reg < {1'b0, len_reg}))
        else $error("division remainder not below divisor");

    a_last_minus: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_vertex.last) |-> m_vertex.v)
        else $error("last flag on a plus-arm vertex");
`endif

endmodule

FILE: rtl/camera_facing_ribbon_trail.sv
`timescale 1ns / 1ps
// Top level of the camera-facing ribbon trail: config register, front, queue, back.
// Depends on crt_pkg, crt_front, crt_seg_queue, crt_back.

// Each accepted point is stored in a WINDOW_LEN-deep history RAM and the
// window is walked newest to oldest; with n points held an item yields
// 2*(n-1) vertices (none while fewer than two points are held). The front
// reads one history entry per segment and queues segment jobs; the back end
// takes one segment at a time, the next only once both vertices of the last
// are loaded, and works it through its shared 32x32 multiplier (six
// cross-product and three square steps), the normalizing shifter, the
// one-digit-a-cycle square root and three 33-step restoring divisions; a
// zero cross product skips to the vertices. A new point is taken as soon
// as the front has queued the last segment of the previous one. half_width
// may be written only while the block is idle; it resets to 0.5 (32768).
module camera_facing_ribbon_trail #(
    parameter int unsigned WINDOW_LEN = crt_pkg::WINDOW_LEN_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [crt_pkg::HW_W-1:0]     cfg_half_width,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  crt_pkg::coord_t              s_point_x,
    input  crt_pkg::coord_t              s_point_y,
    input  crt_pkg::coord_t              s_point_z,
    input  crt_pkg::coord_t              s_camera_x,
    input  crt_pkg::coord_t              s_camera_y,
    input  crt_pkg::coord_t              s_camera_z,
    output logic                         m_valid,
    input  logic                         m_ready,
    output crt_pkg::coord_t              m_vertex_x,
    output crt_pkg::coord_t              m_vertex_y,
    output crt_pkg::coord_t              m_vertex_z,
    output logic [crt_pkg::U_W-1:0]      m_tex_u,
    output logic                         m_tex_v,
    output logic                         m_last_vertex
);
    import crt_pkg::*;

    logic [HW_W-1:0] half_width_reg, half_width_next;
    point_t          s_point;
    point_t          s_camera;
    logic            q_push_valid;
    logic            q_push_ready;
    seg_job_t        q_push_job;
    logic            q_pop_valid;
    logic            q_pop_ready;
    seg_job_t        q_pop_job;
    vertex_t         vtx;

    // Configuration register, always ready
    assign cfg_ready       = 1'b1;
    assign half_width_next = (cfg_valid && cfg_ready) ? cfg_half_width : half_width_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_width_reg <= HW_RESET;
        end else begin
            half_width_reg <= half_width_next;
        end
    end

    assign s_point  = '{x: s_point_x, y: s_point_y, z: s_point_z};
    assign s_camera = '{x: s_camera_x, y: s_camera_y, z: s_camera_z};

    crt_front #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_point    (s_point),
        .s_camera   (s_camera),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_job   (q_push_job)
    );

    crt_seg_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_job   (q_push_job),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_job    (q_pop_job)
    );

    crt_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_job    (q_pop_job),
        .half_width (half_width_reg),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_vertex   (vtx)
    );

    // Split the vertex beat onto its ports
    assign m_vertex_x    = vtx.x;
    assign m_vertex_y    = vtx.y;
    assign m_vertex_z    = vtx.z;
    assign m_tex_u       = vtx.u;
    assign m_tex_v       = vtx.v;
    assign m_last_vertex = vtx.last;

endmodule
